>>> design/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int CNT_W      = ($clog2(TASK_SLOTS + 1) > 5) ? $clog2(TASK_SLOTS + 1) : 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = CFG_IDX_W'(1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [4:0]  TASK_COUNT_RST = 5'd16;
	localparam logic [15:0] TICK_LIMIT_RST = 16'd100;
	localparam logic [15:0] WAIT_MAX       = 16'hFFFF;

	typedef struct packed {
		logic [15:0] arrival;
		logic [2:0]  prio;
		logic [7:0]  remaining;
		logic [15:0] waitc;
	} task_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic scan;
		logic apply;
	} scan_ctrl_t;

	typedef struct packed {
		logic              any_left;
		logic              found;
		logic [SLOT_W-1:0] best_slot;
		logic              finished;
		logic [15:0]       turnaround;
		logic [15:0]       waited;
	} scan_stat_t;

endpackage

>>> design/pps_cell.sv
// One task cell of the rotating task chain.
module pps_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  logic            load_en,
	input  pps_pkg::task_t  load_rec,
	input  pps_pkg::task_t  nbr_rec,
	output pps_pkg::task_t  rec
);

	pps_pkg::task_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (load_en) begin
			rec_q <= load_rec;
		end else if (shift_en) begin
			rec_q <= nbr_rec;
		end
	end

	assign rec = rec_q;

endmodule

>>> design/pps_scan.sv
// Head-of-chain evaluator: picks the served task and updates each task as it passes.
module pps_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pps_pkg::scan_ctrl_t        ctrl,
	input  pps_pkg::task_t             head,
	input  logic [pps_pkg::SLOT_W-1:0] pos,
	input  logic [pps_pkg::CNT_W-1:0]  n_act,
	input  logic [15:0]                tick,
	output pps_pkg::task_t             head_next,
	output pps_pkg::scan_stat_t        stat
);

	logic                       any_left_q;
	logic                       found_q;
	logic [pps_pkg::SLOT_W-1:0] best_q;
	logic [2:0]                 best_prio_q;
	logic                       fin_q;
	logic [15:0]                turn_q;
	logic [15:0]                waited_q;

	logic       part;
	logic       has_work;
	logic       ready;
	logic       is_best;
	logic [7:0] rem_dec;

	always_comb begin
		part     = pps_pkg::CNT_W'(pos) < n_act;
		has_work = head.remaining != 8'd0;
		ready    = part && has_work && (head.arrival <= tick);
		is_best  = pos == best_q;
		rem_dec  = head.remaining - 8'd1;
		head_next = head;
		if (ctrl.apply) begin
			if (is_best) begin
				head_next.remaining = rem_dec;
			end else if (ready && head.waitc != pps_pkg::WAIT_MAX) begin
				head_next.waitc = head.waitc + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_left_q  <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_prio_q <= '0;
			fin_q       <= 1'b0;
			turn_q      <= '0;
			waited_q    <= '0;
		end else if (ctrl.clear) begin
			any_left_q  <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_prio_q <= '0;
			fin_q       <= 1'b0;
			turn_q      <= '0;
			waited_q    <= '0;
		end else if (ctrl.scan) begin
			if (part && has_work) begin
				any_left_q <= 1'b1;
			end
			if (ready && (!found_q || head.prio > best_prio_q)) begin
				found_q     <= 1'b1;
				best_q      <= pos;
				best_prio_q <= head.prio;
			end
		end else if (ctrl.apply && is_best) begin
			fin_q    <= rem_dec == 8'd0;
			turn_q   <= tick - head.arrival + 16'd1;
			waited_q <= head.waitc;
		end
	end

	always_comb begin
		stat.any_left   = any_left_q;
		stat.found      = found_q;
		stat.best_slot  = best_q;
		stat.finished   = fin_q;
		stat.turnaround = turn_q;
		stat.waited     = waited_q;
	end

endmodule

>>> design/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler.
// The input channel takes one beat per item: a load beat (mode 0) writes one task
// slot and restarts time at zero, a tick beat (mode 1) advances scheduling by one
// tick unless it stops. Every item gives exactly one beat on the output channel.
// Task slots live in a ring of cells that rotates one slot per cycle past a head
// evaluator while a tick is scanned or applied. A tick beat needs one full
// rotation to find the served task and a second rotation to update the remaining
// work and waiting counts. A tick that stops or finds no ready task ends after the
// first rotation. A load beat goes straight to the output step. One item is
// worked on at a time; in_ready is high while idle.
// The result goes into an output register, so the next item is accepted while a
// result still waits there. If the receiver stalls, a finished result is held
// until the output register frees.
// The configuration port writes task_count and the tick limit with no wait; writes
// belong to idle periods. Reset clears all slots, sets time to zero, task_count to
// sixteen and the tick limit to one hundred.
module preemptive_priority_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [3:0]                    slot,
	input  logic [15:0]                   arrival,
	input  logic [2:0]                    prio,
	input  logic [7:0]                    burst,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ran,
	output logic [3:0]                    served_slot,
	output logic                          finished,
	output logic [15:0]                   turnaround,
	output logic [15:0]                   waited,
	output logic                          stopped,
	output logic [15:0]                   now
);

	pps_pkg::state_t             state_q, state_nxt;
	logic [pps_pkg::SLOT_W-1:0]  pos_q;
	logic [15:0]                 tick_q;
	logic [15:0]                 now_q;
	logic                        is_load_q;
	logic                        stop_q;
	logic [4:0]                  task_count_q;
	logic [15:0]                 tick_limit_q;
	logic [pps_pkg::CNT_W-1:0]   tc_ext;
	logic [pps_pkg::CNT_W-1:0]   n_act;

	logic                        out_valid_q;
	logic                        ran_q;
	logic [3:0]                  served_q;
	logic                        finished_q;
	logic [15:0]                 turn_q;
	logic [15:0]                 waited_q;
	logic                        stopped_q;
	logic [15:0]                 now_out_q;

	pps_pkg::scan_ctrl_t         ctrl;
	pps_pkg::scan_stat_t         stat;
	pps_pkg::task_t              cell_rec [pps_pkg::TASK_SLOTS];
	pps_pkg::task_t              head_next;
	pps_pkg::task_t              load_rec;

	logic accept;
	logic load_go;
	logic tick_go;
	logic last;
	logic stop_now;
	logic advance;
	logic out_load;
	logic shift_en;
	logic ran_now;
	logic fin_now;

	always_comb begin
		tc_ext = pps_pkg::CNT_W'(task_count_q);
		n_act  = (tc_ext > pps_pkg::CNT_W'(pps_pkg::TASK_SLOTS)) ?
			pps_pkg::CNT_W'(pps_pkg::TASK_SLOTS) : tc_ext;
	end

	always_comb begin
		load_rec.arrival   = arrival;
		load_rec.prio      = prio;
		load_rec.remaining = burst;
		load_rec.waitc     = '0;
	end

	// Output logic of the control state machine.
	always_comb begin
		in_ready   = state_q == pps_pkg::ST_IDLE;
		accept     = in_valid && in_ready;
		load_go    = accept && (mode == pps_pkg::MODE_LOAD);
		tick_go    = accept && (mode == pps_pkg::MODE_TICK);
		ctrl.clear = tick_go;
		ctrl.scan  = state_q == pps_pkg::ST_SCAN;
		ctrl.apply = state_q == pps_pkg::ST_APPLY;
		shift_en   = ctrl.scan || ctrl.apply;
		last       = pos_q == pps_pkg::SLOT_W'(pps_pkg::TASK_SLOTS - 1);
		stop_now   = (tick_q >= tick_limit_q) || !stat.any_left;
		advance    = ((state_q == pps_pkg::ST_DECIDE) && !stop_now && !stat.found) ||
			(ctrl.apply && last);
		out_load   = (state_q == pps_pkg::ST_DONE) && (!out_valid_q || out_ready);
		ran_now    = !is_load_q && !stop_q && stat.found;
		fin_now    = ran_now && stat.finished;
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				if (load_go) begin
					state_nxt = pps_pkg::ST_DONE;
				end else if (tick_go) begin
					state_nxt = pps_pkg::ST_SCAN;
				end
			end
			pps_pkg::ST_SCAN: begin
				if (last) begin
					state_nxt = pps_pkg::ST_DECIDE;
				end
			end
			pps_pkg::ST_DECIDE: begin
				if (stop_now || !stat.found) begin
					state_nxt = pps_pkg::ST_DONE;
				end else begin
					state_nxt = pps_pkg::ST_APPLY;
				end
			end
			pps_pkg::ST_APPLY: begin
				if (last) begin
					state_nxt = pps_pkg::ST_DONE;
				end
			end
			pps_pkg::ST_DONE: begin
				if (out_load) begin
					state_nxt = pps_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pps_pkg::ST_IDLE;
			pos_q     <= '0;
			tick_q    <= '0;
			now_q     <= '0;
			is_load_q <= 1'b0;
			stop_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (shift_en) begin
				pos_q <= last ? '0 : pos_q + 1'b1;
			end
			if (accept) begin
				now_q     <= tick_q;
				is_load_q <= load_go;
				stop_q    <= 1'b0;
			end
			if (state_q == pps_pkg::ST_DECIDE) begin
				stop_q <= stop_now;
			end
			if (load_go) begin
				tick_q <= '0;
			end else if (advance) begin
				tick_q <= tick_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= pps_pkg::TASK_COUNT_RST;
			tick_limit_q <= pps_pkg::TICK_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pps_pkg::REG_TASK_COUNT: task_count_q <= cfg_data[4:0];
				pps_pkg::REG_TICK_LIMIT: tick_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ran_q      <= ran_now;
			served_q   <= ran_now ? 4'(stat.best_slot) : 4'd0;
			finished_q <= fin_now;
			turn_q     <= fin_now ? stat.turnaround : 16'd0;
			waited_q   <= fin_now ? stat.waited : 16'd0;
			stopped_q  <= !is_load_q && stop_q;
			now_out_q  <= now_q;
		end
	end

	for (genvar k = 0; k < pps_pkg::TASK_SLOTS; k++) begin : g_cell
		pps_pkg::task_t nbr;
		if (k == pps_pkg::TASK_SLOTS - 1) begin : g_tail
			assign nbr = head_next;
		end else begin : g_mid
			assign nbr = cell_rec[k+1];
		end
		pps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.load_en  (load_go && (int'(slot) == k)),
			.load_rec (load_rec),
			.nbr_rec  (nbr),
			.rec      (cell_rec[k])
		);
	end

	pps_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.head      (cell_rec[0]),
		.pos       (pos_q),
		.n_act     (n_act),
		.tick      (tick_q),
		.head_next (head_next),
		.stat      (stat)
	);

	assign out_valid   = out_valid_q;
	assign ran         = ran_q;
	assign served_slot = served_q;
	assign finished    = finished_q;
	assign turnaround  = turn_q;
	assign waited      = waited_q;
	assign stopped     = stopped_q;
	assign now         = now_out_q;

endmodule

>>> design/pps_checker.sv
// Port-level checks for the preemptive priority scheduler, bound to the top level.
module pps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ran,
	input logic [3:0]  served_slot,
	input logic        finished,
	input logic [15:0] turnaround,
	input logic [15:0] waited,
	input logic        stopped,
	input logic [15:0] now
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(served_slot) && $stable(now))
		else $error("Output beat changed while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input accepted while an item was still in work.");

	a_idle_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ran |-> served_slot == 4'd0 && !finished && turnaround == 16'd0 &&
			waited == 16'd0)
		else $error("Beat without a served task carries task data.");

	a_finish_served: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> ran && !stopped)
		else $error("Finished task reported on a tick that served nothing.");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

>>> sim/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the preemptive priority scheduler: directed table, then random phases.
module preemptive_priority_scheduler_tb;

	localparam logic [pps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = pps_pkg::CFG_IDX_W'(2);
	localparam logic [pps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = pps_pkg::CFG_IDX_W'(3);
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 2 * pps_pkg::TASK_SLOTS + 8;
	localparam int PHASES = 10;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		logic        mode;
		logic [3:0]  slot;
		logic [15:0] arrival;
		logic [2:0]  prio;
		logic [7:0]  burst;
	} sched_in_t;

	typedef struct packed {
		logic        ran;
		logic [3:0]  served_slot;
		logic        finished;
		logic [15:0] turnaround;
		logic [15:0] waited;
		logic        stopped;
		logic [15:0] now;
	} sched_out_t;

	typedef struct packed {
		sched_in_t  item;
		logic       typed;
		sched_out_t want;
	} script_line_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pps_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic                           mode;
	logic [3:0]                     slot;
	logic [15:0]                    arrival;
	logic [2:0]                     prio;
	logic [7:0]                     burst;
	logic                           out_valid;
	logic                           out_ready;
	logic                           ran;
	logic [3:0]                     served_slot;
	logic                           finished;
	logic [15:0]                    turnaround;
	logic [15:0]                    waited;
	logic                           stopped;
	logic [15:0]                    now;

	logic [15:0] task_arrival [pps_pkg::TASK_SLOTS];
	logic [2:0]  task_prio [pps_pkg::TASK_SLOTS];
	logic [7:0]  task_left [pps_pkg::TASK_SLOTS];
	logic [15:0] task_waited [pps_pkg::TASK_SLOTS];
	logic [15:0] sched_time;
	logic [4:0]  tasks_cfg;
	logic [15:0] limit_cfg;

	sched_out_t due_results [$];
	sched_out_t head_result;
	int         mismatch_count = 0;
	int         idle_cycles = 0;
	bit         calm = 1'b0;

	preemptive_priority_scheduler DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit slot_ready(input int i);
		return task_left[i] != 8'd0 && task_arrival[i] <= sched_time;
	endfunction

	function automatic sched_out_t schedule_item(input sched_in_t it);
		sched_out_t r;
		int         n;
		int         i;
		int         pick;
		bit         any_left;
		r = '0;
		r.now = sched_time;
		if (it.mode == pps_pkg::MODE_LOAD) begin
			task_arrival[it.slot] = it.arrival;
			task_prio[it.slot] = it.prio;
			task_left[it.slot] = it.burst;
			task_waited[it.slot] = 16'd0;
			sched_time = 16'd0;
			return r;
		end
		n = (tasks_cfg > pps_pkg::TASK_SLOTS) ? pps_pkg::TASK_SLOTS : int'(tasks_cfg);
		any_left = 1'b0;
		pick = -1;
		for (i = 0; i < n; i++)
			if (task_left[i] != 8'd0)
				any_left = 1'b1;
		if (sched_time >= limit_cfg || !any_left) begin
			r.stopped = 1'b1;
			return r;
		end
		for (i = 0; i < n; i++)
			if (slot_ready(i) && (pick < 0 || task_prio[i] > task_prio[pick]))
				pick = i;
		if (pick >= 0) begin
			r.ran = 1'b1;
			r.served_slot = pick[3:0];
			for (i = 0; i < n; i++)
				if (i != pick && slot_ready(i) && task_waited[i] != pps_pkg::WAIT_MAX)
					task_waited[i] = task_waited[i] + 16'd1;
			task_left[pick] = task_left[pick] - 8'd1;
			if (task_left[pick] == 8'd0) begin
				r.finished = 1'b1;
				r.turnaround = sched_time - task_arrival[pick] + 16'd1;
				r.waited = task_waited[pick];
			end
		end
		sched_time = sched_time + 16'd1;
		return r;
	endfunction

	function automatic script_line_t script_line(input logic m, input int s, input int a,
			input int p, input int b, input bit chk, input int r, input int ss, input int f,
			input int ta, input int w, input int st, input int nw);
		script_line_t x;
		x.item.mode = m;
		x.item.slot = s[3:0];
		x.item.arrival = a[15:0];
		x.item.prio = p[2:0];
		x.item.burst = b[7:0];
		x.typed = chk;
		x.want.ran = r[0];
		x.want.served_slot = ss[3:0];
		x.want.finished = f[0];
		x.want.turnaround = ta[15:0];
		x.want.waited = w[15:0];
		x.want.stopped = st[0];
		x.want.now = nw[15:0];
		return x;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		mismatch_count++;
	endtask

	task automatic send_item(input sched_in_t it, input bit typed, input sched_out_t want);
		int         gap;
		sched_out_t seen;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= it.mode;
		slot <= it.slot;
		arrival <= it.arrival;
		prio <= it.prio;
		burst <= it.burst;
		do @(posedge clk); while (!(in_valid && in_ready));
		seen = schedule_item(it);
		due_results.push_back(typed ? want : seen);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pps_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			pps_pkg::REG_TASK_COUNT: tasks_cfg = data[4:0];
			pps_pkg::REG_TICK_LIMIT: limit_cfg = data;
			default: ;
		endcase
	endtask

	initial begin : receiver
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 11);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected beat", 16'd0, 16'd0);
			end else begin
				head_result = due_results.pop_front();
				if (ran !== head_result.ran)
					report_mismatch("ran", 16'(head_result.ran), 16'(ran));
				if (served_slot !== head_result.served_slot)
					report_mismatch("served_slot", 16'(head_result.served_slot),
						16'(served_slot));
				if (finished !== head_result.finished)
					report_mismatch("finished", 16'(head_result.finished), 16'(finished));
				if (turnaround !== head_result.turnaround)
					report_mismatch("turnaround", head_result.turnaround, turnaround);
				if (waited !== head_result.waited)
					report_mismatch("waited", head_result.waited, waited);
				if (stopped !== head_result.stopped)
					report_mismatch("stopped", 16'(head_result.stopped), 16'(stopped));
				if (now !== head_result.now)
					report_mismatch("now", head_result.now, now);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		script_line_t script [$];
		sched_in_t    it;
		int           n_act;
		int           loads;
		int           work;
		int           ticks;
		int           budget;
		int           sent;
		logic [15:0]  tasks_w;
		logic [15:0]  limit_w;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= pps_pkg::MODE_LOAD;
		slot <= '0;
		arrival <= '0;
		prio <= '0;
		burst <= '0;
		for (int i = 0; i < pps_pkg::TASK_SLOTS; i++) begin
			task_arrival[i] = '0;
			task_prio[i] = '0;
			task_left[i] = '0;
			task_waited[i] = '0;
		end
		sched_time = '0;
		tasks_cfg = pps_pkg::TASK_COUNT_RST;
		limit_cfg = pps_pkg::TICK_LIMIT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// mode, slot, arrival, prio, burst | check, ran, slot, fin, turn, wait, stop, now
		script.push_back(script_line(pps_pkg::MODE_TICK, 0, 0, 0, 0, TYPED,
			0, 0, 0, 0, 0, 1, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 0, 0, 7, 2, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 1, 0, 7, 1, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 2, 1, 0, 1, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 3, 0, 3, 0, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 15, 65535, 1, 255, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		repeat (5)
			script.push_back(script_line(pps_pkg::MODE_TICK, 0, 0, 0, 0, PREDICTED,
				0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 15, 0, 7, 0, PREDICTED,
			0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_TICK, 0, 0, 0, 0, TYPED,
			0, 0, 0, 0, 0, 1, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 4, 2, 5, 3, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_LOAD, 5, 0, 2, 4, TYPED,
			0, 0, 0, 0, 0, 0, 0));
		repeat (7)
			script.push_back(script_line(pps_pkg::MODE_TICK, 0, 0, 0, 0, PREDICTED,
				0, 0, 0, 0, 0, 0, 0));
		script.push_back(script_line(pps_pkg::MODE_TICK, 0, 0, 0, 0, TYPED,
			0, 0, 0, 0, 0, 1, 7));
		foreach (script[k])
			send_item(script[k].item, script[k].typed, script[k].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin tasks_w = 16'd16; limit_w = 16'd100; end
				1: begin tasks_w = 16'd1; limit_w = 16'd65535; end
				2: begin tasks_w = 16'd31; limit_w = 16'd40; end
				3: begin tasks_w = 16'd0; limit_w = 16'd100; end
				4: begin tasks_w = 16'd8; limit_w = 16'd0; end
				5: begin tasks_w = 16'd17; limit_w = 16'd65535; end
				default: begin
					tasks_w = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(17, 31))
						: 16'($urandom_range(1, 16));
					limit_w = 16'($urandom_range(10, 200));
				end
			endcase
			write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
				16'($urandom()));
			write_reg(pps_pkg::REG_TASK_COUNT, {11'($urandom_range(0, 2047)), tasks_w[4:0]});
			write_reg(pps_pkg::REG_TICK_LIMIT, limit_w);
			n_act = (tasks_cfg > pps_pkg::TASK_SLOTS) ? pps_pkg::TASK_SLOTS : int'(tasks_cfg);
			budget = (ph == 3 || ph == 4) ? 25 : 80;
			sent = 0;
			while (sent < budget) begin
				calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 9) < 8) begin
					loads = $urandom_range(1, 6);
					work = 0;
					repeat (loads) begin
						it = $urandom();
						it.mode = pps_pkg::MODE_LOAD;
						if (n_act > 0 && $urandom_range(0, 7) != 0)
							it.slot = 4'($urandom_range(0, n_act - 1));
						if ($urandom_range(0, 7) != 0)
							it.arrival = 16'($urandom_range(0, 12));
						if ($urandom_range(0, 9) != 0)
							it.burst = 8'($urandom_range(0, 6));
						work += it.burst;
						send_item(it, PREDICTED, '0);
					end
					ticks = work + $urandom_range(0, 4);
					if (ticks > 40)
						ticks = 40;
					repeat (ticks) begin
						it = $urandom();
						it.mode = pps_pkg::MODE_TICK;
						send_item(it, PREDICTED, '0);
					end
					sent += loads + ticks;
				end else begin
					repeat ($urandom_range(1, 6)) begin
						it = $urandom();
						send_item(it, PREDICTED, '0);
						sent++;
					end
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
design/pps_pkg.sv
design/pps_cell.sv
design/pps_scan.sv
design/preemptive_priority_scheduler.sv
design/pps_checker.sv
sim/preemptive_priority_scheduler_tb.sv
